### hdl/cp1251_to_utf8_transcoder_macros.svh
// Assertion macros for the Windows-1251 to UTF-8 transcoder.
`ifndef CP1251_TO_UTF8_TRANSCODER_MACROS_SVH
`define CP1251_TO_UTF8_TRANSCODER_MACROS_SVH
`ifndef SYNTHESIS
`define C2U_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define C2U_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define C2U_ASSERT(lbl, clk, rstn, prop, msg)
`define C2U_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

### hdl/c2u_pkg.sv
// Constants and code table for the Windows-1251 to UTF-8 transcoder.
package c2u_pkg;

  localparam int unsigned CountBits = 16;
  localparam int unsigned LimitBits = 16;
  localparam int unsigned CmpBits   = (CountBits > LimitBits) ? CountBits : LimitBits;
  localparam int unsigned ByteBits  = 8;
  localparam int unsigned CodeBits  = 3 * ByteBits;

  localparam logic [CountBits-1:0] CountMax = {CountBits{1'b1}};
  localparam logic [ByteBits-1:0]  TermByte = '0;

  typedef logic [ByteBits-1:0] byte_t;
  typedef logic [CodeBits-1:0] code_t;

  // UTF-8 bytes of codes 0x80..0xFF, first byte in bits 7:0, zero is undefined
  localparam code_t Utf8Tab [128] = '{
    24'h0082D0, 24'h0083D0, 24'h9A80E2, 24'h0093D1,
    24'h9E80E2, 24'hA680E2, 24'hA080E2, 24'hA180E2,
    24'hAC82E2, 24'hB080E2, 24'h0089D0, 24'hB980E2,
    24'h008AD0, 24'h008CD0, 24'h008BD0, 24'h008FD0,
    24'h0092D1, 24'h9880E2, 24'h9980E2, 24'h9C80E2,
    24'h9D80E2, 24'hA280E2, 24'h9380E2, 24'h9480E2,
    24'h000000, 24'hA284E2, 24'h0099D1, 24'hBA80E2,
    24'h009AD1, 24'h009CD1, 24'h009BD1, 24'h009FD1,
    24'h00A0C2, 24'h008ED0, 24'h009ED1, 24'h0088D0,
    24'h00A4C2, 24'h0090D2, 24'h00A6C2, 24'h00A7C2,
    24'h0081D0, 24'h00A9C2, 24'h0084D0, 24'h00ABC2,
    24'h00ACC2, 24'h00ADC2, 24'h00AEC2, 24'h0087D0,
    24'h00B0C2, 24'h00B1C2, 24'h0086D0, 24'h0096D1,
    24'h0091D2, 24'h00B5C2, 24'h00B6C2, 24'h00B7C2,
    24'h0091D1, 24'h9684E2, 24'h0094D1, 24'h00BBC2,
    24'h0098D1, 24'h0085D0, 24'h0095D1, 24'h0097D1,
    24'h0090D0, 24'h0091D0, 24'h0092D0, 24'h0093D0,
    24'h0094D0, 24'h0095D0, 24'h0096D0, 24'h0097D0,
    24'h0098D0, 24'h0099D0, 24'h009AD0, 24'h009BD0,
    24'h009CD0, 24'h009DD0, 24'h009ED0, 24'h009FD0,
    24'h00A0D0, 24'h00A1D0, 24'h00A2D0, 24'h00A3D0,
    24'h00A4D0, 24'h00A5D0, 24'h00A6D0, 24'h00A7D0,
    24'h00A8D0, 24'h00A9D0, 24'h00AAD0, 24'h00ABD0,
    24'h00ACD0, 24'h00ADD0, 24'h00AED0, 24'h00AFD0,
    24'h00B0D0, 24'h00B1D0, 24'h00B2D0, 24'h00B3D0,
    24'h00B4D0, 24'h00B5D0, 24'h00B6D0, 24'h00B7D0,
    24'h00B8D0, 24'h00B9D0, 24'h00BAD0, 24'h00BBD0,
    24'h00BCD0, 24'h00BDD0, 24'h00BED0, 24'h00BFD0,
    24'h0080D1, 24'h0081D1, 24'h0082D1, 24'h0083D1,
    24'h0084D1, 24'h0085D1, 24'h0086D1, 24'h0087D1,
    24'h0088D1, 24'h0089D1, 24'h008AD1, 24'h008BD1,
    24'h008CD1, 24'h008DD1, 24'h008ED1, 24'h008FD1
  };

endpackage

### hdl/cp1251_to_utf8_transcoder.sv
// Windows-1251 to UTF-8 transcoder, top level.
//
//   channel  direction  handshake             word
//   in       input      in_valid_i/in_stall_o  in_byte_i
//   out      output     out_valid_o/out_stall_i out_byte_o, last_of_run_o, string_end_o
//   cfg      input      cfg_valid_i/cfg_ready_o cfg_data_i (char_limit)
//
// An input word is registered, then translated into the result register once the
// previous run has drained or its last word is leaving; its 1 to 3 output words (1 for
// ASCII, 2 or 3 for high codes) then leave one per cycle while the output is not stalled.
// A dropped word or the undefined code leaves no output.
// Reset clears the limit, the character count and the closed flag.
// An output stall holds the result register; input is taken while its last word drains.
`include "cp1251_to_utf8_transcoder_macros.svh"

module cp1251_to_utf8_transcoder (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [c2u_pkg::ByteBits-1:0]     in_byte_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [c2u_pkg::ByteBits-1:0]     out_byte_o,
  output logic                             last_of_run_o,
  output logic                             string_end_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [c2u_pkg::LimitBits-1:0]    cfg_data_i
);
  import c2u_pkg::*;

  logic                 s1_vld_q, s1_vld_d;
  byte_t                s1_byte_q;
  logic [LimitBits-1:0] limit_q;
  logic [CountBits-1:0] count_q, count_d;
  logic                 closed_q, closed_d;
  code_t                res_q, res_d;
  logic [1:0]           rem_q, rem_d;
  logic                 res_end_q, res_end_d;

  logic  in_fire, out_fire, s1_adv;
  code_t code;
  code_t emit_data;
  logic [1:0] emit_n;
  logic  emit_end;
  logic  count_inc;
  logic  at_limit;

  assign cfg_ready_o = 1'b1;
  assign out_valid_o = (rem_q != 2'd0);
  assign out_byte_o  = res_q[ByteBits-1:0];
  assign last_of_run_o = (rem_q == 2'd1);
  assign string_end_o  = res_end_q;

  assign out_fire = out_valid_o && !out_stall_i;
  assign s1_adv   = s1_vld_q && ((rem_q == 2'd0) || ((rem_q == 2'd1) && out_fire));
  assign in_stall_o = s1_vld_q && !s1_adv;
  assign in_fire  = in_valid_i && !in_stall_o;

  assign code     = Utf8Tab[s1_byte_q[ByteBits-2:0]];
  assign at_limit = (limit_q != '0) && (CmpBits'(count_q) >= CmpBits'(limit_q));

  always_comb begin
    emit_data = '0;
    emit_n    = 2'd0;
    emit_end  = 1'b0;
    count_inc = 1'b0;
    closed_d  = closed_q;
    count_d   = count_q;
    if (s1_byte_q == TermByte) begin
      closed_d = 1'b0;
      count_d  = '0;
      if (!closed_q) begin
        emit_n   = 2'd1;
        emit_end = 1'b1;
      end
    end else if (closed_q) begin
      emit_n = 2'd0;
    end else if (at_limit) begin
      closed_d = 1'b1;
      emit_n   = 2'd1;
      emit_end = 1'b1;
    end else if (!s1_byte_q[ByteBits-1]) begin
      emit_data = CodeBits'(s1_byte_q);
      emit_n    = 2'd1;
      count_inc = 1'b1;
    end else if (code != '0) begin
      emit_data = code;
      emit_n    = (code[CodeBits-1 -: ByteBits] != '0) ? 2'd3 : 2'd2;
      count_inc = 1'b1;
    end
    if (count_inc && (count_q != CountMax)) begin
      count_d = count_q + 1'b1;
    end
  end

  always_comb begin
    res_d     = res_q;
    rem_d     = rem_q;
    res_end_d = res_end_q;
    if (s1_adv) begin
      res_d     = emit_data;
      rem_d     = emit_n;
      res_end_d = emit_end;
    end else if (out_fire) begin
      res_d = res_q >> ByteBits;
      rem_d = rem_q - 2'd1;
    end
  end

  assign s1_vld_d = in_fire ? 1'b1 : (s1_adv ? 1'b0 : s1_vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      limit_q   <= '0;
      count_q   <= '0;
      closed_q  <= 1'b0;
      rem_q     <= 2'd0;
      res_end_q <= 1'b0;
    end else begin
      s1_vld_q  <= s1_vld_d;
      rem_q     <= rem_d;
      res_end_q <= res_end_d;
      if (cfg_valid_i && cfg_ready_o) begin
        limit_q <= cfg_data_i;
      end
      if (s1_adv) begin
        count_q  <= count_d;
        closed_q <= closed_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (in_fire) begin
      s1_byte_q <= in_byte_i;
    end
  end

  `C2U_ASSERT(a_term_shape, clk_i, rst_ni,
    (out_valid_o && string_end_o) |-> (out_byte_o == TermByte && last_of_run_o),
    "terminator word must be a single zero byte")
  `C2U_ASSERT(a_stall_needs_item, clk_i, rst_ni, in_stall_o |-> s1_vld_q,
    "input stalled with empty input register")
  `C2U_ASSERT(a_close_sends_term, clk_i, rst_ni,
    $rose(closed_q) |-> (out_valid_o && string_end_o && last_of_run_o),
    "string closed without a terminator queued")
  `C2U_NEVER(a_long_term, clk_i, rst_ni, (rem_q > 2'd1) && res_end_q,
    "terminator marked on a multi-byte run")

endmodule
